[src/spl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter package
// Widths, register map, payload types and the control store of the sequencer.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 24;
  localparam int DIV_STEPS     = SAMPLE_BITS - 1;
  localparam int CNT_BITS      = $clog2(DIV_STEPS);
  localparam int MUL_A_BITS    = SAMPLE_BITS + 1;
  localparam int MUL_B_BITS    = ((COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS) + 1;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int ADDR_BITS     = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int STEP_BITS     = 4;

  localparam logic [SAMPLE_BITS-1:0] UNITY       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_HALF = {2'b01, {(SAMPLE_BITS-2){1'b0}}};
  localparam logic [COEF_BITS-1:0]   COEF_HALF   = {1'b1, {(COEF_BITS-1){1'b0}}};

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = UNITY;
  localparam logic [COEF_BITS-1:0]   ATTACK_RST    = COEF_BITS'(16431300);
  localparam logic [COEF_BITS-1:0]   RELEASE_RST   = COEF_BITS'(16775469);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2,
    REG_ENABLE    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic        [SAMPLE_BITS-1:0] gain_now;
    logic                          block_last_out;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] threshold_level;
    logic [COEF_BITS-1:0]   attack_coefficient;
    logic [COEF_BITS-1:0]   release_coefficient;
    logic                   limiter_enable;
  } cfg_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_LOAD        = 4'd0,
    OP_PEAK        = 4'd1,
    OP_DIVSTEP     = 4'd2,
    OP_TARGET      = 4'd3,
    OP_MUL_GAIN    = 4'd4,
    OP_GAIN        = 4'd5,
    OP_MUL_LEFT    = 4'd6,
    OP_SCALE_LEFT  = 4'd7,
    OP_MUL_RIGHT   = 4'd8,
    OP_SCALE_RIGHT = 4'd9,
    OP_EMIT        = 4'd10,
    OP_PASS        = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_ITEM  = 3'd2,
    COND_DISABLED = 3'd3,
    COND_LOOP     = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_e;

  typedef logic [STEP_BITS-1:0] step_t;

  typedef struct packed {
    op_e   op;
    cond_e hold_on;
    cond_e jump_on;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic item_in;
    logic disabled;
    logic loop_more;
    logic out_busy;
  } status_t;

  localparam step_t ST_LOAD        = 4'd0;
  localparam step_t ST_PEAK        = 4'd1;
  localparam step_t ST_DIV         = 4'd2;
  localparam step_t ST_TARGET      = 4'd3;
  localparam step_t ST_MUL_GAIN    = 4'd4;
  localparam step_t ST_GAIN        = 4'd5;
  localparam step_t ST_MUL_LEFT    = 4'd6;
  localparam step_t ST_SCALE_LEFT  = 4'd7;
  localparam step_t ST_MUL_RIGHT   = 4'd8;
  localparam step_t ST_SCALE_RIGHT = 4'd9;
  localparam step_t ST_EMIT        = 4'd10;
  localparam step_t ST_PASS        = 4'd11;

  // Control store. A step holds while its hold condition is true, then jumps
  // to its target if the jump condition is true, else moves to the next step.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      ST_LOAD:        w = '{op: OP_LOAD,        hold_on: COND_NO_ITEM,  jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_PEAK:        w = '{op: OP_PEAK,        hold_on: COND_NEVER,    jump_on: COND_DISABLED,
                            target: ST_PASS};
      ST_DIV:         w = '{op: OP_DIVSTEP,     hold_on: COND_NEVER,    jump_on: COND_LOOP,
                            target: ST_DIV};
      ST_TARGET:      w = '{op: OP_TARGET,      hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_MUL_GAIN:    w = '{op: OP_MUL_GAIN,    hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_GAIN:        w = '{op: OP_GAIN,        hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_MUL_LEFT:    w = '{op: OP_MUL_LEFT,    hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_SCALE_LEFT:  w = '{op: OP_SCALE_LEFT,  hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_MUL_RIGHT:   w = '{op: OP_MUL_RIGHT,   hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_SCALE_RIGHT: w = '{op: OP_SCALE_RIGHT, hold_on: COND_NEVER,    jump_on: COND_NEVER,
                            target: ST_LOAD};
      ST_EMIT:        w = '{op: OP_EMIT,        hold_on: COND_OUT_BUSY, jump_on: COND_ALWAYS,
                            target: ST_LOAD};
      ST_PASS:        w = '{op: OP_PASS,        hold_on: COND_NEVER,    jump_on: COND_ALWAYS,
                            target: ST_EMIT};
      default:        w = '{op: OP_LOAD,        hold_on: COND_NEVER,    jump_on: COND_ALWAYS,
                            target: ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

[src/spl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter channels
// Valid/ready channels for sample pairs in and scaled results out.
// ----------------------------------------------------------------------------
interface spl_in_if;
  import spl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spl_out_if;
  import spl_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/spl_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter sequencer
// Step counter over the control store, with hold and jump conditions.
// ----------------------------------------------------------------------------
module spl_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spl_pkg::status_t status_i,
  output spl_pkg::ucode_t  ctrl_o
);
  import spl_pkg::*;

  step_t  step_q, step_d;
  ucode_t word;
  logic   hold, jump;

  function automatic logic cond_true(cond_e c, status_t st);
    logic r;
    case (c)
      COND_NEVER:    r = 1'b0;
      COND_ALWAYS:   r = 1'b1;
      COND_NO_ITEM:  r = !st.item_in;
      COND_DISABLED: r = st.disabled;
      COND_LOOP:     r = st.loop_more;
      COND_OUT_BUSY: r = st.out_busy;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    word = ucode_rom(step_q);
    hold = cond_true(word.hold_on, status_i);
    jump = cond_true(word.jump_on, status_i);
    if (hold) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = word.target;
    end else begin
      step_d = step_t'(step_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;

`ifndef SYNTHESIS
  // The divide step repeats itself until the iteration count runs out.
  a_div_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.op == OP_DIVSTEP && status_i.loop_more) |=> (ctrl_o.op == OP_DIVSTEP))
    else $error("divide loop left early");
`endif

endmodule

[src/spl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter datapath
// Peak detect, restoring divider, one shared multiplier and result registers.
// ----------------------------------------------------------------------------
module spl_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spl_pkg::op_e       op_i,
  input  logic               load_i,
  input  spl_pkg::in_item_t  item_i,
  input  spl_pkg::cfg_t      cfg_i,
  output logic               loop_more_o,
  output spl_pkg::out_item_t result_o
);
  import spl_pkg::*;

  logic signed [SAMPLE_BITS-1:0] left_q, right_q, lres_q, rres_q;
  logic                          last_q;
  logic        [SAMPLE_BITS-1:0] peak_q, quot_q, target_q, gain_q;
  logic        [SAMPLE_BITS:0]   rem_q;
  logic        [CNT_BITS-1:0]    cnt_q;
  logic signed [PROD_BITS-1:0]   prod_q;

  logic        [SAMPLE_BITS-1:0] mag_l, mag_r, peak_now, gain_new;
  logic        [SAMPLE_BITS:0]   rem_shift, rem_sub;
  logic                          rem_ge;
  logic        [COEF_BITS-1:0]   coef;
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0]   gsum, gdelta, gnew, ssum, squot;
  logic signed [SAMPLE_BITS-1:0] scaled;

  always_comb begin
    mag_l    = left_q[SAMPLE_BITS-1] ? (~left_q + 1'b1) : left_q;
    mag_r    = right_q[SAMPLE_BITS-1] ? (~right_q + 1'b1) : right_q;
    peak_now = (mag_l > mag_r) ? mag_l : mag_r;

    // One quotient bit a step; a remainder below the peak stays below it.
    rem_shift = {rem_q[SAMPLE_BITS-1:0], 1'b0};
    rem_sub   = rem_shift - {1'b0, peak_q};
    rem_ge    = rem_shift >= {1'b0, peak_q};

    coef = (target_q < gain_q) ? cfg_i.attack_coefficient : cfg_i.release_coefficient;

    // The one-pole update is written as target + c*(gain - target).
    case (op_i)
      OP_MUL_GAIN: begin
        mul_a = $signed({1'b0, gain_q}) - $signed({1'b0, target_q});
        mul_b = $signed(MUL_B_BITS'(coef));
      end
      OP_MUL_RIGHT: begin
        mul_a = MUL_A_BITS'(right_q);
        mul_b = $signed(MUL_B_BITS'(gain_q));
      end
      default: begin
        mul_a = MUL_A_BITS'(left_q);
        mul_b = $signed(MUL_B_BITS'(gain_q));
      end
    endcase

    gsum   = prod_q + $signed(PROD_BITS'(COEF_HALF));
    gdelta = gsum >>> COEF_BITS;
    gnew   = gdelta + $signed(PROD_BITS'(target_q));
    if (gnew > $signed(PROD_BITS'(UNITY))) begin
      gain_new = UNITY;
    end else begin
      gain_new = gnew[SAMPLE_BITS-1:0];
    end

    ssum  = prod_q + $signed(PROD_BITS'(SAMPLE_HALF));
    squot = ssum >>> (SAMPLE_BITS - 1);
    if (squot > $signed(PROD_BITS'(UNITY - 1'b1))) begin
      scaled = $signed(UNITY - 1'b1);
    end else if (squot < -$signed(PROD_BITS'(UNITY))) begin
      scaled = $signed(UNITY);
    end else begin
      scaled = squot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= UNITY;
      cnt_q  <= '0;
    end else begin
      case (op_i)
        OP_PEAK:    cnt_q  <= CNT_BITS'(DIV_STEPS - 1);
        OP_DIVSTEP: cnt_q  <= cnt_q - 1'b1;
        OP_GAIN:    gain_q <= gain_new;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= item_i.left_in;
      right_q <= item_i.right_in;
      last_q  <= item_i.block_last_in;
    end
    case (op_i)
      OP_PEAK: begin
        peak_q <= peak_now;
        rem_q  <= {1'b0, cfg_i.threshold_level};
        quot_q <= '0;
      end
      OP_DIVSTEP: begin
        rem_q  <= rem_ge ? rem_sub : rem_shift;
        quot_q <= {quot_q[SAMPLE_BITS-2:0], rem_ge};
      end
      OP_TARGET:      target_q <= (peak_q > cfg_i.threshold_level) ? quot_q : UNITY;
      OP_MUL_GAIN,
      OP_MUL_LEFT,
      OP_MUL_RIGHT:   prod_q <= mul_a * mul_b;
      OP_SCALE_LEFT:  lres_q <= scaled;
      OP_SCALE_RIGHT: rres_q <= scaled;
      OP_PASS: begin
        lres_q <= left_q;
        rres_q <= right_q;
      end
      default: ;
    endcase
  end

  assign loop_more_o = (cnt_q != '0);
  assign result_o    = '{left_out: lres_q, right_out: rres_q, gain_now: gain_q,
                         block_last_out: last_q};

`ifndef SYNTHESIS
  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= UNITY)
    else $error("smoothed gain above unity");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_DIVSTEP && peak_q > cfg_i.threshold_level) |-> (rem_q < {1'b0, peak_q}))
    else $error("divider remainder not below divisor");
`endif

endmodule

[src/stereo_peak_limiter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter core
// Feedforward peak limiter with one-pole attack/release gain smoothing.
// ----------------------------------------------------------------------------
// One sample pair is processed at a time. With the limiter enabled an item
// passes through the transfer step, a peak step, 23 steps of the restoring
// divider that forms threshold/peak, and seven steps through the single
// shared multiplier for the gain update and the two scaled samples, then
// the output step. With the limiter disabled it goes through the transfer,
// peak, pass and output steps. The result sits in an output register, so the
// next pair is taken as soon as the sequencer is back at its first step; a
// stalled output only adds the cycles the result cannot leave.
module stereo_peak_limiter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  spl_in_if.sink                             in_i,
  spl_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spl_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [spl_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [spl_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import spl_pkg::*;

  cfg_t      cfg_q;
  reg_idx_e  reg_idx;
  logic      cfg_write;
  ucode_t    ctrl;
  status_t   status;
  logic      accept, loop_more, out_busy, out_load;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, result;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_level     <= THRESHOLD_RST;
      cfg_q.attack_coefficient  <= ATTACK_RST;
      cfg_q.release_coefficient <= RELEASE_RST;
      cfg_q.limiter_enable      <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_q.threshold_level     <= pwdata[SAMPLE_BITS-1:0];
        REG_ATTACK:    cfg_q.attack_coefficient  <= pwdata[COEF_BITS-1:0];
        REG_RELEASE:   cfg_q.release_coefficient <= pwdata[COEF_BITS-1:0];
        REG_ENABLE:    cfg_q.limiter_enable      <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_BITS'(cfg_q.threshold_level);
      REG_ATTACK:    prdata = APB_DATA_BITS'(cfg_q.attack_coefficient);
      REG_RELEASE:   prdata = APB_DATA_BITS'(cfg_q.release_coefficient);
      REG_ENABLE:    prdata = APB_DATA_BITS'(cfg_q.limiter_enable);
      default:       prdata = '0;
    endcase
  end

  // Handshakes and sequencer status.
  assign in_i.ready = (ctrl.op == OP_LOAD);
  assign accept     = in_i.valid && in_i.ready;
  assign out_busy   = out_valid_q && !out_o.ready;
  assign out_load   = (ctrl.op == OP_EMIT) && !out_busy;

  assign status = '{item_in: accept, disabled: !cfg_q.limiter_enable,
                    loop_more: loop_more, out_busy: out_busy};

  spl_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  spl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (ctrl.op),
    .load_i      (accept),
    .item_i      (in_i.data),
    .cfg_i       (cfg_q),
    .loop_more_o (loop_more),
    .result_o    (result)
  );

  // Output register: holds a finished result until its transfer.
  assign out_valid_d = out_load || out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("second item taken while one is in progress");
`endif

endmodule
